/* src/apfp_pkg.sv */
package apfp_pkg;

  // parse phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b000_0001,
    PH_LEN    = 7'b000_0010,
    PH_OPC    = 7'b000_0100,
    PH_LOCAL  = 7'b000_1000,
    PH_COUNT  = 7'b001_0000,
    PH_ACK    = 7'b010_0000,
    PH_REMOTE = 7'b100_0000
  } apfp_phase_t;

  // field kinds carried on the result word
  localparam logic [2:0] KIND_LENGTH  = 3'd0;
  localparam logic [2:0] KIND_OPCODE  = 3'd1;
  localparam logic [2:0] KIND_LOCAL   = 3'd2;
  localparam logic [2:0] KIND_COUNT   = 3'd3;
  localparam logic [2:0] KIND_ACK_ID  = 3'd4;
  localparam logic [2:0] KIND_REMOTE  = 3'd5;
  localparam logic [2:0] KIND_SHORT   = 3'd6;

  // last byte position of each multi-byte field
  localparam logic [2:0] LEN_LAST_BYTE  = 3'd1;
  localparam logic [2:0] ACK_LAST_BYTE  = 3'd3;
  localparam logic [2:0] SESS_LAST_BYTE = 3'd7;

  localparam logic [15:0] MIN_LENGTH_RESET = 16'd14;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  key_id;
    logic [7:0]  ack_index;
    logic        done;
  } apfp_res_t;

endpackage

/* src/apfp_parse.sv */
module apfp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic [15:0]       min_length,
  output apfp_pkg::apfp_res_t res
);

  apfp_pkg::apfp_phase_t phase_r, phase_nxt, phase_eff;
  logic [2:0]  bif_r, bif_nxt, bif_eff;
  logic [63:0] acc_r, acc_nxt, acc_eff, acc_sh;
  logic [7:0]  rem_r, rem_nxt, rem_eff, rem_dec;
  logic [7:0]  cnt_r, cnt_nxt, cnt_eff;

  // a first byte restarts the parse in the length phase with the field state freshly cleared
  always_comb begin
    phase_eff = first_byte ? apfp_pkg::PH_LEN : phase_r;
    bif_eff   = first_byte ? 3'd0  : bif_r;
    acc_eff   = first_byte ? 64'd0 : acc_r;
    rem_eff   = first_byte ? 8'd0  : rem_r;
    cnt_eff   = first_byte ? 8'd0  : cnt_r;
    acc_sh    = {acc_eff[55:0], data_byte};
    rem_dec   = rem_eff - 8'd1;
  end

  always_comb begin
    phase_nxt     = phase_eff;
    bif_nxt       = bif_eff + 3'd1;
    acc_nxt       = acc_sh;
    rem_nxt       = rem_eff;
    cnt_nxt       = cnt_eff;
    res.valid     = 1'b0;
    res.kind      = apfp_pkg::KIND_LENGTH;
    res.value     = acc_sh;
    res.key_id    = 3'd0;
    res.ack_index = 8'd0;
    res.done      = 1'b0;
    unique case (phase_eff)
      apfp_pkg::PH_LEN: begin
        if (bif_eff == apfp_pkg::LEN_LAST_BYTE) begin
          bif_nxt   = 3'd0;
          acc_nxt   = 64'd0;
          res.valid = 1'b1;
          res.value = {48'd0, acc_sh[15:0]};
          if (acc_sh[15:0] < min_length) begin
            phase_nxt = apfp_pkg::PH_IDLE;
            res.kind  = apfp_pkg::KIND_SHORT;
            res.done  = 1'b1;
          end else begin
            phase_nxt = apfp_pkg::PH_OPC;
          end
        end
      end
      apfp_pkg::PH_OPC: begin
        phase_nxt  = apfp_pkg::PH_LOCAL;
        bif_nxt    = 3'd0;
        acc_nxt    = 64'd0;
        res.valid  = 1'b1;
        res.kind   = apfp_pkg::KIND_OPCODE;
        res.value  = {59'd0, data_byte[7:3]};
        res.key_id = data_byte[2:0];
      end
      apfp_pkg::PH_LOCAL: begin
        if (bif_eff == apfp_pkg::SESS_LAST_BYTE) begin
          phase_nxt = apfp_pkg::PH_COUNT;
          bif_nxt   = 3'd0;
          acc_nxt   = 64'd0;
          res.valid = 1'b1;
          res.kind  = apfp_pkg::KIND_LOCAL;
        end
      end
      apfp_pkg::PH_COUNT: begin
        phase_nxt = (data_byte == 8'd0) ? apfp_pkg::PH_IDLE : apfp_pkg::PH_ACK;
        bif_nxt   = 3'd0;
        acc_nxt   = 64'd0;
        rem_nxt   = data_byte;
        cnt_nxt   = 8'd0;
        res.valid = 1'b1;
        res.kind  = apfp_pkg::KIND_COUNT;
        res.value = {56'd0, data_byte};
        res.done  = (data_byte == 8'd0);
      end
      apfp_pkg::PH_ACK: begin
        if (bif_eff == apfp_pkg::ACK_LAST_BYTE) begin
          phase_nxt     = (rem_dec == 8'd0) ? apfp_pkg::PH_REMOTE : apfp_pkg::PH_ACK;
          bif_nxt       = 3'd0;
          acc_nxt       = 64'd0;
          rem_nxt       = rem_dec;
          cnt_nxt       = cnt_eff + 8'd1;
          res.valid     = 1'b1;
          res.kind      = apfp_pkg::KIND_ACK_ID;
          res.value     = {32'd0, acc_sh[31:0]};
          res.ack_index = cnt_eff;
        end
      end
      apfp_pkg::PH_REMOTE: begin
        if (bif_eff == apfp_pkg::SESS_LAST_BYTE) begin
          phase_nxt = apfp_pkg::PH_IDLE;
          bif_nxt   = 3'd0;
          acc_nxt   = 64'd0;
          res.valid = 1'b1;
          res.kind  = apfp_pkg::KIND_REMOTE;
          res.done  = 1'b1;
        end
      end
      default: begin
        // idle: bytes are dropped
        phase_nxt = apfp_pkg::PH_IDLE;
        bif_nxt   = bif_eff;
        acc_nxt   = acc_eff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= apfp_pkg::PH_IDLE;
      bif_r   <= 3'd0;
      acc_r   <= 64'd0;
      rem_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (en) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // idle holds a cleared field
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == apfp_pkg::PH_IDLE |-> bif_r == 3'd0 && acc_r == 64'd0)
    else $error("idle phase with a partial field");

  // only the session fields run past four bytes
  a_bif_range: assert property (@(posedge clk) disable iff (!rst_n)
    bif_r > apfp_pkg::ACK_LAST_BYTE |->
      phase_r == apfp_pkg::PH_LOCAL || phase_r == apfp_pkg::PH_REMOTE)
    else $error("byte count out of range for phase");

  // a last result leaves the parser idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.valid && res.done |=> phase_r == apfp_pkg::PH_IDLE)
    else $error("packet done without returning to idle");

  // ack phase always has acks left to take
  a_ack_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == apfp_pkg::PH_ACK |-> rem_r != 8'd0)
    else $error("ack phase with no acks remaining");

endmodule

/* src/ack_packet_field_parser.sv */
// Acknowledgement packet field parser: takes one packet byte per word on the
// in_ stream (in_tuser marks the first byte of a packet) and returns one word
// per completed field on the out_ stream: length, opcode with key id, local
// session id, ack count, each ack id with its index, and the remote session
// id when the count is nonzero. A length below min_length gives a too-short
// word and the rest of the packet is dropped; out_tlast flags the last word
// of a packet. A byte word is accepted every cycle while the output register
// is empty or being taken; a result passes through the input register, then
// the parse step into the output register.
// min_length resets to 14 and is to be written through cfg_wr_en only while
// idle; the user must keep to this, as the block itself does not enforce it.
module ack_packet_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // min_length
  // byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // data_byte
  input  logic [0:0]  in_tuser,      // first_byte
  // field stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,     // field_value[63:0], key_id[66:64], ack_index[74:67], zero pad
  output logic [2:0]  out_tuser,     // field_kind
  output logic        out_tlast      // packet_done
);

  logic [15:0] min_len_r;
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_first_r;
  logic        advance;
  logic        out_v_r;
  apfp_pkg::apfp_res_t res, out_res_r;

  // pipeline moves when the output word is empty or being taken
  assign advance   = !out_v_r || out_tready;
  assign in_tready = advance || !in_v_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= apfp_pkg::MIN_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser[0];
    end
  end

  // parse step, state advances once per byte
  apfp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (in_v_r && advance),
    .data_byte  (in_byte_r),
    .first_byte (in_first_r),
    .min_length (min_len_r),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_res_r.ack_index, out_res_r.key_id, out_res_r.value};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.done;

endmodule
